### hw/rtl/lzrq_pkg.sv
// shared types and constants for the longest zero run range query block
package lzrq_pkg;

  localparam int DEFAULT_MAX_LEN = 1024;
  localparam int LEN_W           = 11;
  localparam int POS_IN_W        = 10;
  localparam int RUN_OUT_W       = 11;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  typedef enum logic [0:0] {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } lzrq_func_t;

  typedef struct packed {
    lzrq_func_t          func;
    logic [POS_IN_W-1:0] position;
    logic                is_zero;
    logic [POS_IN_W-1:0] range_start;
    logic [POS_IN_W-1:0] range_end;
  } lzrq_req_t;

  typedef struct packed {
    logic [RUN_OUT_W-1:0] longest_zero_run;
    logic                 range_error;
  } lzrq_rsp_t;

  typedef struct packed {
    logic start;
    logic resp_ack;
  } lzrq_ctl_t;

  typedef struct packed {
    logic idle;
    logic resp_valid;
  } lzrq_stat_t;

endpackage

### hw/rtl/lzrq_if.sv
// channel interfaces: request, response and configuration write
interface lzrq_req_if;
  logic                          valid;
  logic                          ready;
  lzrq_pkg::lzrq_func_t          func;
  logic [lzrq_pkg::POS_IN_W-1:0] position;
  logic                          is_zero;
  logic [lzrq_pkg::POS_IN_W-1:0] range_start;
  logic [lzrq_pkg::POS_IN_W-1:0] range_end;

  modport source (output valid, func, position, is_zero, range_start, range_end,
                  input ready);
  modport sink   (input valid, func, position, is_zero, range_start, range_end,
                  output ready);
endinterface

interface lzrq_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [lzrq_pkg::RUN_OUT_W-1:0] longest_zero_run;
  logic                           range_error;

  modport source (output valid, longest_zero_run, range_error, input ready);
  modport sink   (input valid, longest_zero_run, range_error, output ready);
endinterface

interface lzrq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lzrq_pkg::LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### hw/rtl/lzrq_ram.sv
// generic single write port, single read port ram with registered read
module lzrq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/lzrq_walker.sv
// tree walker: path update for writes, range decomposition for queries
module lzrq_walker #(
  parameter int MAX_LEN = lzrq_pkg::DEFAULT_MAX_LEN
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lzrq_pkg::lzrq_req_t        req,
  input  lzrq_pkg::lzrq_ctl_t        ctl,
  input  logic [lzrq_pkg::LEN_W-1:0] length_in_use,
  output lzrq_pkg::lzrq_stat_t       stat,
  output lzrq_pkg::lzrq_rsp_t        resp
);

  localparam int RUN_W  = $clog2(MAX_LEN + 1);
  localparam int POS_W  = $clog2(MAX_LEN);
  localparam int DEPTH  = 2 * MAX_LEN;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int LEVELS = POS_W;
  localparam int STK_AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SP_W   = $clog2(LEVELS + 1);
  localparam int WORD_W = 3 * RUN_W;
  localparam logic [POS_W-1:0] ROOT_HI = POS_W'(MAX_LEN - 1);

  typedef struct packed {
    logic [RUN_W-1:0] span;
    logic [RUN_W-1:0] pref;
    logic [RUN_W-1:0] suff;
    logic [RUN_W-1:0] best;
  } run_t;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WDOWN  = 7'b0000010,
    ST_WUP_RD = 7'b0000100,
    ST_WUP_MG = 7'b0001000,
    ST_QNODE  = 7'b0010000,
    ST_QMG    = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_t;

  function automatic run_t merge_runs(run_t a, run_t b);
    run_t             m;
    logic [RUN_W-1:0] link;
    link   = a.suff + b.pref;
    m.span = a.span + b.span;
    m.pref = a.pref + ((a.pref == a.span) ? b.pref : '0);
    m.suff = b.suff + ((b.suff == b.span) ? a.suff : '0);
    m.best = (a.best > b.best) ? a.best : b.best;
    if (link > m.best) begin
      m.best = link;
    end
    return m;
  endfunction

  function automatic logic [POS_W-1:0] node_mid(logic [POS_W-1:0] lo, logic [POS_W-1:0] hi);
    return lo + ((hi - lo) >> 1);
  endfunction

  function automatic logic [IDX_W-1:0] right_idx(logic [IDX_W-1:0] idx,
                                                 logic [POS_W-1:0] lo,
                                                 logic [POS_W-1:0] mid);
    return idx + ((IDX_W'(mid - lo) + IDX_W'(1)) << 1);
  endfunction

  state_t           state;
  logic [SP_W-1:0]  sp;
  logic [IDX_W-1:0] stk_idx [LEVELS];
  logic [POS_W-1:0] stk_lo  [LEVELS];
  logic [POS_W-1:0] stk_hi  [LEVELS];

  logic [IDX_W-1:0] cur_idx;
  logic [POS_W-1:0] cur_lo;
  logic [POS_W-1:0] cur_hi;
  logic [POS_W-1:0] pos;
  logic             bit_val;
  logic [POS_W-1:0] qs;
  logic [POS_W-1:0] qe;
  run_t             carry;
  run_t             acc;
  lzrq_pkg::lzrq_rsp_t result;

  logic [POS_W-1:0] cur_mid;
  logic [IDX_W-1:0] cur_ri;
  logic [SP_W-1:0]  sp_top;
  logic [IDX_W-1:0] top_idx;
  logic [POS_W-1:0] top_lo;
  logic [POS_W-1:0] top_hi;
  logic [POS_W-1:0] top_mid;
  logic             top_left;
  run_t             rd_run;
  run_t             up_run;
  run_t             q_run;
  run_t             q_merged;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic write_ok;
  logic query_err;

  lzrq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    cur_mid  = node_mid(cur_lo, cur_hi);
    cur_ri   = right_idx(cur_idx, cur_lo, cur_mid);
    sp_top   = sp - SP_W'(1);
    top_idx  = stk_idx[sp_top[STK_AW-1:0]];
    top_lo   = stk_lo[sp_top[STK_AW-1:0]];
    top_hi   = stk_hi[sp_top[STK_AW-1:0]];
    top_mid  = node_mid(top_lo, top_hi);
    top_left = (pos <= top_mid);

    rd_run.pref = ram_rdata[3*RUN_W-1:2*RUN_W];
    rd_run.suff = ram_rdata[2*RUN_W-1:RUN_W];
    rd_run.best = ram_rdata[RUN_W-1:0];
    rd_run.span = top_left ? RUN_W'(top_hi - top_mid) : RUN_W'(top_mid - top_lo) + RUN_W'(1);
    up_run      = top_left ? merge_runs(carry, rd_run) : merge_runs(rd_run, carry);

    q_run      = rd_run;
    q_run.span = RUN_W'(cur_hi - cur_lo) + RUN_W'(1);
    q_merged   = merge_runs(acc, q_run);

    write_ok  = 32'(req.position) < 32'(MAX_LEN);
    query_err = (lzrq_pkg::LEN_W'(req.range_end) >= length_in_use) ||
                (32'(req.range_end) >= 32'(MAX_LEN));
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_idx;
    ram_wdata = {RUN_W'(bit_val), RUN_W'(bit_val), RUN_W'(bit_val)};
    ram_raddr = cur_idx;
    unique case (state)
      ST_WDOWN: begin
        ram_we = (cur_lo == cur_hi);
      end
      ST_WUP_RD: begin
        ram_raddr = top_left ? right_idx(top_idx, top_lo, top_mid) : top_idx + IDX_W'(1);
      end
      ST_WUP_MG: begin
        ram_we    = 1'b1;
        ram_waddr = top_idx;
        ram_wdata = {up_run.pref, up_run.suff, up_run.best};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            pos                     <= POS_W'(req.position);
            bit_val                 <= req.is_zero;
            qs                      <= POS_W'(req.range_start);
            qe                      <= POS_W'(req.range_end);
            cur_idx                 <= '0;
            cur_lo                  <= '0;
            cur_hi                  <= ROOT_HI;
            sp                      <= '0;
            acc                     <= '0;
            result.longest_zero_run <= '0;
            result.range_error      <= query_err;
            if (req.func == lzrq_pkg::FUNC_WRITE) begin
              if (write_ok) begin
                state <= ST_WDOWN;
              end
            end else if (query_err) begin
              state <= ST_RESULT;
            end else if (req.range_start > req.range_end) begin
              state <= ST_RESULT;
            end else begin
              state <= ST_QNODE;
            end
          end
        end
        ST_WDOWN: begin
          if (cur_lo == cur_hi) begin
            carry <= '{span: RUN_W'(1), pref: RUN_W'(bit_val), suff: RUN_W'(bit_val),
                       best: RUN_W'(bit_val)};
            state <= (sp == '0) ? ST_IDLE : ST_WUP_RD;
          end else begin
            stk_idx[sp[STK_AW-1:0]] <= cur_idx;
            stk_lo[sp[STK_AW-1:0]]  <= cur_lo;
            stk_hi[sp[STK_AW-1:0]]  <= cur_hi;
            sp                      <= sp + SP_W'(1);
            if (pos <= cur_mid) begin
              cur_idx <= cur_idx + IDX_W'(1);
              cur_hi  <= cur_mid;
            end else begin
              cur_idx <= cur_ri;
              cur_lo  <= cur_mid + POS_W'(1);
            end
          end
        end
        ST_WUP_RD: begin
          state <= ST_WUP_MG;
        end
        ST_WUP_MG: begin
          carry <= up_run;
          sp    <= sp_top;
          state <= (sp_top == '0) ? ST_IDLE : ST_WUP_RD;
        end
        ST_QNODE: begin
          if (qs <= cur_lo && cur_hi <= qe) begin
            state <= ST_QMG;
          end else if (qe <= cur_mid) begin
            cur_idx <= cur_idx + IDX_W'(1);
            cur_hi  <= cur_mid;
          end else if (qs > cur_mid) begin
            cur_idx <= cur_ri;
            cur_lo  <= cur_mid + POS_W'(1);
          end else begin
            stk_idx[sp[STK_AW-1:0]] <= cur_ri;
            stk_lo[sp[STK_AW-1:0]]  <= cur_mid + POS_W'(1);
            stk_hi[sp[STK_AW-1:0]]  <= cur_hi;
            sp                      <= sp + SP_W'(1);
            cur_idx                 <= cur_idx + IDX_W'(1);
            cur_hi                  <= cur_mid;
          end
        end
        ST_QMG: begin
          acc <= q_merged;
          if (sp == '0) begin
            result.longest_zero_run <= lzrq_pkg::RUN_OUT_W'(q_merged.best);
            state                   <= ST_RESULT;
          end else begin
            cur_idx <= top_idx;
            cur_lo  <= top_lo;
            cur_hi  <= top_hi;
            sp      <= sp_top;
            state   <= ST_QNODE;
          end
        end
        ST_RESULT: begin
          if (ctl.resp_ack) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat.idle       = (state == ST_IDLE);
  assign stat.resp_valid = (state == ST_RESULT);
  assign resp            = result;

endmodule

### hw/rtl/longest_zero_run_range_query.sv
// top level: longest zero run range query over a segment tree bitmap
//
// The bitmap of MAX_LEN positions lives as a segment tree in one ram of
// 2*MAX_LEN words (prefix, suffix and longest zero run per node). One
// transaction is worked on at a time; the ram read port sets the pace.
// The tree has D = ceil(log2(MAX_LEN)) levels (10 at 1024). A write
// descends to the leaf, then reads the sibling and writes back per level.
// A query visits nodes from the root and merges each node that the range
// covers; one with a range error or start after end skips the walk. A
// finished result sits in the output register so the next transaction
// can start while it waits. The cfg channel is always ready and does not
// wait for idle. The ram is not cleared after reset: a query must only
// cover positions written since reset. length_in_use resets to 1024 and
// is to be written through the cfg channel only while the block is idle.
module longest_zero_run_range_query #(
  parameter int MAX_LEN = lzrq_pkg::DEFAULT_MAX_LEN
) (
  input logic         clk,
  input logic         rst,
  lzrq_req_if.sink    req,
  lzrq_rsp_if.source  rsp,
  lzrq_cfg_if.sink    cfg
);

  logic [lzrq_pkg::LEN_W-1:0] length_in_use;
  lzrq_pkg::lzrq_req_t        walk_req;
  lzrq_pkg::lzrq_ctl_t        walk_ctl;
  lzrq_pkg::lzrq_stat_t       walk_stat;
  lzrq_pkg::lzrq_rsp_t        walk_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      length_in_use <= lzrq_pkg::LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      length_in_use <= cfg.data;
    end
  end

  assign walk_req.func        = req.func;
  assign walk_req.position    = req.position;
  assign walk_req.is_zero     = req.is_zero;
  assign walk_req.range_start = req.range_start;
  assign walk_req.range_end   = req.range_end;

  assign req.ready         = walk_stat.idle;
  assign walk_ctl.start    = req.valid && walk_stat.idle;
  assign walk_ctl.resp_ack = walk_stat.resp_valid && (!rsp.valid || rsp.ready);

  lzrq_walker #(
    .MAX_LEN (MAX_LEN)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .req           (walk_req),
    .ctl           (walk_ctl),
    .length_in_use (length_in_use),
    .stat          (walk_stat),
    .resp          (walk_rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (walk_ctl.resp_ack) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_ctl.resp_ack) begin
      rsp.longest_zero_run <= walk_rsp.longest_zero_run;
      rsp.range_error      <= walk_rsp.range_error;
    end
  end

endmodule

### test/tb_longest_zero_run_range_query.sv
// self-checking testbench for the longest zero run range query block
`timescale 1ns / 1ps

module tb_longest_zero_run_range_query;
  import lzrq_pkg::*;

  localparam int MAP_LEN = DEFAULT_MAX_LEN;
  // loaded prefix; non-error queries stay inside it
  localparam int WRITTEN = 520;

  // bitmap-level predictor: scans the held bitmap instead of walking a tree
  class zero_run_scoreboard;
    bit               zero_map [MAP_LEN];
    logic [LEN_W-1:0] length_in_use = LEN_RESET;
    lzrq_rsp_t        expected_q [$];
    int               error_count = 0;
    int               writes_seen = 0;
    int               queries_seen = 0;
    int               range_errors_seen = 0;
    int               responses_checked = 0;

    function void set_length(logic [LEN_W-1:0] value);
      length_in_use = value;
    endfunction

    function int unsigned query_limit();
      return (length_in_use > MAP_LEN) ? MAP_LEN : length_in_use;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(lzrq_req_t r);
      int unsigned lim;
      int unsigned run;
      int unsigned best;
      lzrq_rsp_t   e;
      if (r.func == FUNC_WRITE) begin
        if (r.position < MAP_LEN) zero_map[r.position] = r.is_zero;
        writes_seen++;
      end else begin
        lim = query_limit();
        e.longest_zero_run = '0;
        e.range_error = 1'b0;
        if (r.range_end >= lim) begin
          e.range_error = 1'b1;
          range_errors_seen++;
        end else if (r.range_start <= r.range_end) begin
          run = 0;
          best = 0;
          for (int unsigned p = r.range_start; p <= r.range_end; p++) begin
            run = zero_map[p[POS_IN_W-1:0]] ? run + 1 : 0;
            if (run > best) best = run;
          end
          e.longest_zero_run = RUN_OUT_W'(best);
        end
        expected_q = {expected_q, e};
        queries_seen++;
      end
    endfunction

    function void check_response(lzrq_rsp_t got);
      lzrq_rsp_t e;
      if (expected_q.size() == 0) begin
        $error("response with no query outstanding: longest_zero_run %0d range_error %0d",
               got.longest_zero_run, got.range_error);
        error_count++;
        return;
      end
      e = expected_q.pop_front();
      responses_checked++;
      if (got.longest_zero_run !== e.longest_zero_run) begin
        $error("longest_zero_run: expected %0d, actual %0d",
               e.longest_zero_run, got.longest_zero_run);
        error_count++;
      end
      if (got.range_error !== e.range_error) begin
        $error("range_error: expected %0d, actual %0d", e.range_error, got.range_error);
        error_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  lzrq_req_if req_ch ();
  lzrq_rsp_if rsp_ch ();
  lzrq_cfg_if cfg_ch ();

  zero_run_scoreboard sb = new();

  int unsigned snd_idle_pct = 6;
  int unsigned rcv_idle_pct = 53;
  int          length_settings = 0;

  longest_zero_run_range_query u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic lzrq_req_t make_write(input int unsigned pos, input bit zbit);
    lzrq_req_t r;
    r.func        = FUNC_WRITE;
    r.position    = pos[POS_IN_W-1:0];
    r.is_zero     = zbit;
    r.range_start = POS_IN_W'($urandom_range(MAP_LEN - 1));
    r.range_end   = POS_IN_W'($urandom_range(MAP_LEN - 1));
    return r;
  endfunction

  function automatic lzrq_req_t make_range(input int unsigned qs, input int unsigned qe);
    lzrq_req_t r;
    r.func        = FUNC_QUERY;
    r.position    = POS_IN_W'($urandom_range(MAP_LEN - 1));
    r.is_zero     = 1'($urandom_range(1));
    r.range_start = qs[POS_IN_W-1:0];
    r.range_end   = qe[POS_IN_W-1:0];
    return r;
  endfunction

  function automatic lzrq_req_t make_query(input int unsigned lim);
    int unsigned kind;
    int unsigned qs;
    int unsigned qe;
    int unsigned edge_w;
    int unsigned reach;
    kind = $urandom_range(99);
    reach = (lim < WRITTEN) ? lim : WRITTEN;
    edge_w = (reach - 1 < 16) ? reach - 1 : 16;
    if (kind < 10 && lim < MAP_LEN) begin
      qs = $urandom_range(MAP_LEN - 1);
      qe = $urandom_range(MAP_LEN - 1, lim);
    end else if (kind < 50) begin
      qs = $urandom_range(reach - 1);
      qe = qs + $urandom_range(32);
      if (qe > reach - 1) qe = reach - 1;
    end else if (kind < 75) begin
      qs = $urandom_range(MAP_LEN - 1);
      qe = $urandom_range(reach - 1);
    end else begin
      qs = $urandom_range(edge_w);
      qe = $urandom_range(reach - 1, reach - 1 - edge_w);
    end
    return make_range(qs, qe);
  endfunction

  // called just after a rising edge; valid stays high into the next call
  task automatic send_req(input lzrq_req_t r);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= r.func;
    req_ch.position    <= r.position;
    req_ch.is_zero     <= r.is_zero;
    req_ch.range_start <= r.range_start;
    req_ch.range_end   <= r.range_end;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic wait_for_idle();
    int w;
    req_ch.valid <= 1'b0;
    w = 0;
    while (sb.pending() != 0 && w < 50000) begin
      @(posedge clk);
      w++;
    end
    // a write may still be walking the tree
    repeat (64) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_length(value);
    length_settings++;
  endtask

  task automatic run_random_segment(input int unsigned item_goal);
    int unsigned sent;
    int unsigned kind;
    int unsigned lim;
    int unsigned pos;
    int unsigned burst;
    bit          zbit;
    lim = sb.query_limit();
    sent = 0;
    while (sent < item_goal) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        // burst of equal bits builds long runs
        pos = $urandom_range(WRITTEN - 1);
        burst = $urandom_range(40, 4);
        zbit = 1'($urandom_range(1));
        for (int unsigned k = 0; k < burst && pos + k < MAP_LEN; k++) begin
          send_req(make_write(pos + k, zbit));
          sent++;
        end
      end else if (kind < 45) begin
        send_req(make_write($urandom_range(MAP_LEN - 1), 1'($urandom_range(1))));
        sent++;
      end else begin
        send_req(make_query(lim));
        sent++;
      end
    end
  endtask

  initial begin
    lzrq_rsp_t got;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.longest_zero_run = rsp_ch.longest_zero_run;
        got.range_error      = rsp_ch.range_error;
        sb.check_response(got);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  initial begin
    logic [LEN_W-1:0] seg_len [6];
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= FUNC_WRITE;
    req_ch.position    <= '0;
    req_ch.is_zero     <= 1'b0;
    req_ch.range_start <= '0;
    req_ch.range_end   <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.data        <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all zeros over the loaded prefix gives one long run
    for (int unsigned p = 0; p < WRITTEN; p++) send_req(make_write(p, 1'b1));
    send_req(make_range(0, WRITTEN - 1));
    send_req(make_range(WRITTEN - 1, 0));
    send_req(make_write(2, 1'b0));
    send_req(make_write(WRITTEN - 1, 1'b0));
    send_req(make_write(WRITTEN - 4, 1'b0));
    send_req(make_range(0, 5));
    send_req(make_range(2, 2));
    send_req(make_range(0, 1));
    send_req(make_range(3, 3));
    send_req(make_range(WRITTEN - 3, WRITTEN - 1));
    send_req(make_range(WRITTEN - 1, WRITTEN - 1));
    send_req(make_range(0, WRITTEN - 1));
    send_req(make_range(5, 4));
    wait_for_idle();

    // end beyond the length, alone and with start after end, and ranges inside it
    write_length(LEN_W'(WRITTEN - 1));
    send_req(make_range(0, WRITTEN - 1));
    send_req(make_range(WRITTEN + 100, WRITTEN - 1));
    send_req(make_range(0, WRITTEN - 2));
    send_req(make_range(WRITTEN - 2, WRITTEN - 2));
    send_req(make_range(700, 300));
    send_req(make_range(0, MAP_LEN - 1));

    seg_len[0] = LEN_W'(1);
    seg_len[1] = LEN_W'(MAP_LEN);
    seg_len[2] = LEN_W'($urandom_range(MAP_LEN - 2, 2));
    seg_len[3] = LEN_W'(2);
    seg_len[4] = LEN_W'(MAP_LEN - 1);
    seg_len[5] = LEN_W'($urandom_range(MAP_LEN, 1));
    for (int s = 0; s < 6; s++) begin
      wait_for_idle();
      if (s == 2) begin
        snd_idle_pct = 53;
        rcv_idle_pct = 6;
      end else if (s == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_length(seg_len[s]);
      run_random_segment(28);
    end

    wait_for_idle();
    if (sb.pending() != 0) begin
      $error("%0d expected responses never arrived", sb.pending());
      sb.error_count += sb.pending();
    end
    $display("covered %0d write and %0d query transactions (%0d out of range) over %0d lengths",
             sb.writes_seen, sb.queries_seen, sb.range_errors_seen, length_settings);
    $display("%0d responses compared, %0d mismatches", sb.responses_checked, sb.error_count);
    if (sb.error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
